// File: hw/rtl/spq_pkg.sv
// Shared types and constants for the sorted priority queue.
`timescale 1ns / 1ps

package spq_pkg;

   localparam int DEFAULT_DEPTH = 16;

   localparam int FUNC_W   = 2;
   localparam int VALUE_W  = 32;
   localparam int STATUS_W = 2;
   localparam int INDEX_W  = 4;
   localparam int COUNT_W  = 5;
   localparam int RSP_W    = 48;

   localparam logic [FUNC_W-1:0] OP_INSERT = 2'd0;
   localparam logic [FUNC_W-1:0] OP_REMOVE = 2'd1;
   localparam logic [FUNC_W-1:0] OP_FIND   = 2'd2;

   localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
   localparam logic [STATUS_W-1:0] ST_MISSING = 2'd1;
   localparam logic [STATUS_W-1:0] ST_FULL    = 2'd2;

   typedef struct packed {
      logic accept;
      logic rd;
      logic step;
      logic put;
      logic head;
      logic out_load;
   } cmd_type;

   typedef struct packed {
      logic start_head;
      logic start_put;
      logic go_head;
      logic go_put;
      logic out_free;
   } sts_type;

endpackage

// File: hw/rtl/spq_ctrl.sv
// Sequencer for the sorted priority queue: steps through scan, write and result.
`timescale 1ns / 1ps

module spq_ctrl
   import spq_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_tvalid,
   output logic    req_tready,
   input  sts_type sts,
   output cmd_type cmd
);

   typedef enum logic [5:0] {
      S_IDLE = 6'b000001,
      S_RD   = 6'b000010,
      S_CMP  = 6'b000100,
      S_PUT  = 6'b001000,
      S_HEAD = 6'b010000,
      S_OUT  = 6'b100000
   } state_type;

   state_type state_ff, state_in;

   assign req_tready = (state_ff == S_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.accept = 1'b1;
               if (sts.start_head) begin
                  state_in = S_HEAD;
               end else if (sts.start_put) begin
                  state_in = S_PUT;
               end else begin
                  state_in = S_RD;
               end
            end
         end
         S_RD: begin
            cmd.rd   = 1'b1;
            state_in = S_CMP;
         end
         S_CMP: begin
            cmd.step = 1'b1;
            if (sts.go_head) begin
               state_in = S_HEAD;
            end else if (sts.go_put) begin
               state_in = S_PUT;
            end else begin
               state_in = S_RD;
            end
         end
         S_PUT: begin
            cmd.put  = 1'b1;
            state_in = S_HEAD;
         end
         S_HEAD: begin
            cmd.head = 1'b1;
            state_in = S_OUT;
         end
         S_OUT: begin
            if (sts.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// File: hw/rtl/spq_dpath.sv
// Datapath for the sorted priority queue: entry store, scan registers, result beat.
`timescale 1ns / 1ps

module spq_dpath
   import spq_pkg::*;
#(
   parameter int DEPTH = DEFAULT_DEPTH
)
(
   input  logic               clock,
   input  logic               reset,
   input  cmd_type            cmd,
   output sts_type            sts,
   input  logic [VALUE_W-1:0] req_tdata,
   input  logic [FUNC_W-1:0]  req_tuser,
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   output logic [RSP_W-1:0]   rsp_tdata,
   output logic [STATUS_W-1:0] rsp_tuser
);

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   logic [VALUE_W-1:0] entries_ff [DEPTH];
   logic [VALUE_W-1:0] rd_data_ff;

   logic [FUNC_W-1:0]        func_ff, func_in;
   logic signed [VALUE_W-1:0] value_ff, value_in;
   logic [CW-1:0]            occ_ff, occ_in;
   logic [CW-1:0]            i_ff, i_in;
   logic                     found_ff, found_in;
   logic [AW-1:0]            idx_ff, idx_in;
   logic [STATUS_W-1:0]      status_ff, status_in;

   logic                     rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0]      rsp_status_ff, rsp_status_in;
   logic [INDEX_W-1:0]       rsp_index_ff, rsp_index_in;
   logic [VALUE_W-1:0]       rsp_head_ff, rsp_head_in;
   logic                     rsp_hvalid_ff, rsp_hvalid_in;
   logic [COUNT_W-1:0]       rsp_count_ff, rsp_count_in;

   logic          full, empty, ge, match, last, scan_rf;
   logic [CW-1:0] i_dec, i_inc;
   logic          rd_en, wr_en;
   logic [AW-1:0] rd_addr, wr_addr;
   logic [VALUE_W-1:0] wr_data;

   assign full    = (occ_ff == CW'(DEPTH));
   assign empty   = (occ_ff == '0);
   assign ge      = ($signed(rd_data_ff) >= value_ff);
   assign match   = (rd_data_ff == value_ff);
   assign i_dec   = i_ff - CW'(1);
   assign i_inc   = i_ff + CW'(1);
   assign last    = (i_inc == occ_ff);
   assign scan_rf = (req_tuser == OP_REMOVE) || (req_tuser == OP_FIND);

   always_comb begin
      sts.start_head = ((req_tuser == OP_INSERT) && full) || (scan_rf && empty) ||
                       !((req_tuser == OP_INSERT) || scan_rf);
      sts.start_put  = (req_tuser == OP_INSERT) && !full && empty;
      if (func_ff == OP_INSERT) begin
         sts.go_head = 1'b0;
         sts.go_put  = !ge || (i_ff == CW'(1));
      end else begin
         sts.go_head = (match && !found_ff && (func_ff == OP_FIND)) || last;
         sts.go_put  = 1'b0;
      end
      sts.out_free = !rsp_valid_ff || rsp_tready;
   end

   // store port selection
   always_comb begin
      rd_en   = cmd.rd || cmd.head;
      rd_addr = '0;
      if (cmd.rd) begin
         rd_addr = (func_ff == OP_INSERT) ? i_dec[AW-1:0] : i_ff[AW-1:0];
      end
      wr_en   = 1'b0;
      wr_addr = i_ff[AW-1:0];
      wr_data = rd_data_ff;
      if (cmd.put) begin
         wr_en   = 1'b1;
         wr_data = value_ff;
      end else if (cmd.step) begin
         if (func_ff == OP_INSERT) begin
            wr_en = ge;
         end else begin
            wr_en   = found_ff && (func_ff == OP_REMOVE);
            wr_addr = i_dec[AW-1:0];
         end
      end
   end

   always_comb begin
      func_in   = func_ff;
      value_in  = value_ff;
      occ_in    = occ_ff;
      i_in      = i_ff;
      found_in  = found_ff;
      idx_in    = idx_ff;
      status_in = status_ff;

      if (cmd.accept) begin
         func_in  = req_tuser;
         value_in = req_tdata;
         i_in     = (req_tuser == OP_INSERT) ? occ_ff : '0;
         found_in = 1'b0;
         idx_in   = '0;
         if ((req_tuser == OP_INSERT) && full) begin
            status_in = ST_FULL;
         end else if (scan_rf && empty) begin
            status_in = ST_MISSING;
         end else begin
            status_in = ST_OK;
         end
      end

      if (cmd.step) begin
         if (func_ff == OP_INSERT) begin
            if (ge) begin
               i_in = i_dec;
            end
         end else begin
            i_in = i_inc;
            if (match && !found_ff) begin
               found_in = 1'b1;
               idx_in   = i_ff[AW-1:0];
            end
            if (sts.go_head) begin
               if (!(found_ff || match)) begin
                  status_in = ST_MISSING;
               end else if (func_ff == OP_REMOVE) begin
                  occ_in = occ_ff - CW'(1);
               end
            end
         end
      end

      if (cmd.put) begin
         occ_in = occ_ff + CW'(1);
      end
   end

   always_comb begin
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_status_in = rsp_status_ff;
      rsp_index_in  = rsp_index_ff;
      rsp_head_in   = rsp_head_ff;
      rsp_hvalid_in = rsp_hvalid_ff;
      rsp_count_in  = rsp_count_ff;
      if (cmd.out_load) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = status_ff;
         rsp_index_in  = INDEX_W'(idx_ff);
         rsp_head_in   = empty ? '0 : rd_data_ff;
         rsp_hvalid_in = !empty;
         rsp_count_in  = COUNT_W'(occ_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         entries_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= entries_ff[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         occ_ff       <= occ_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      func_ff       <= func_in;
      value_ff      <= value_in;
      i_ff          <= i_in;
      found_ff      <= found_in;
      idx_ff        <= idx_in;
      status_ff     <= status_in;
      rsp_status_ff <= rsp_status_in;
      rsp_index_ff  <= rsp_index_in;
      rsp_head_ff   <= rsp_head_in;
      rsp_hvalid_ff <= rsp_hvalid_in;
      rsp_count_ff  <= rsp_count_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tdata  = {6'b0, rsp_count_ff, rsp_hvalid_ff, rsp_head_ff, rsp_index_ff};

endmodule

// File: hw/rtl/sorted_priority_queue.sv
// Top level of the sorted priority queue: sequencer plus datapath.
// Each request beat is accepted in S_IDLE; every entry compared then takes an S_RD and an S_CMP
// step on the single-port store, a stored insert adds S_PUT, and S_HEAD and S_OUT load the response
// beat (no entry is compared for refused inserts, empty lookups and unused codes). A new request is
// taken only in S_IDLE, after the last response is loaded, and is taken while that response waits.
// Reset (synchronous, active high) empties the queue and drops any pending response.
`timescale 1ns / 1ps

module sorted_priority_queue
   import spq_pkg::*;
#(
   parameter int DEPTH = DEFAULT_DEPTH
)
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [VALUE_W-1:0]  req_tdata,   // value
   input  logic [FUNC_W-1:0]   req_tuser,   // func
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [RSP_W-1:0]    rsp_tdata,   // found_index, head_value, head_valid, entry_count
   output logic [STATUS_W-1:0] rsp_tuser    // status
);

   cmd_type cmd;
   sts_type sts;

   spq_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   spq_dpath #(
      .DEPTH (DEPTH)
   ) u_dpath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .sts        (sts),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule
